### sv/cobs_dfr_pkg.sv
// Shared types and constants for the COBS stream packet deframer.
// No dependencies; imported by the step logic and the top level.
`default_nettype none

package cobs_dfr_pkg;

    // Stream byte codes
    localparam logic [7:0] BYTE_DELIM    = 8'h00;
    localparam logic [7:0] CODE_FULL_GRP = 8'hFF;

    // Header sizes in decoded bytes
    localparam logic [1:0] HDR_LEN_RELIABLE = 2'd1;
    localparam logic [1:0] HDR_LEN_FULL     = 2'd3;

    // Header byte slots
    localparam logic [1:0] HDR_SLOT_HEADER = 2'd0;
    localparam logic [1:0] HDR_SLOT_SEQ    = 2'd1;

    // Configuration port
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned DATA_W    = 32;
    localparam logic        REG_RELIABLE_MODE = 1'b0;  // word address of reliable_mode

    // Deframer state carried from one stream byte to the next
    typedef struct packed {
        logic [7:0] group_left;
        logic       zero_pending;
        logic [1:0] decoded_count;
        logic [7:0] header;
        logic [7:0] seq;
        logic       guaranteed;
        logic [7:0] held_byte;
        logic       held_valid;
    } dfr_state_t;

    // One result item
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] seq_num;
        logic       guaranteed;
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       last;
    } dfr_result_t;

endpackage

`default_nettype wire

### sv/cobs_dfr_step.sv
// Next-state and result logic for one encoded byte of the deframer.
// Depends on cobs_dfr_pkg for the state and result structs.
`default_nettype none

module cobs_dfr_step (
    input  wire logic                      reliable_mode,
    input  wire logic [7:0]                in_byte,
    input  wire cobs_dfr_pkg::dfr_state_t  state,
    output cobs_dfr_pkg::dfr_state_t       state_next,
    output cobs_dfr_pkg::dfr_result_t      result,
    output logic                           emit
);
    import cobs_dfr_pkg::*;

    logic [1:0] hdr_len;
    logic       take;
    logic [7:0] dec_byte;

    assign hdr_len = reliable_mode ? HDR_LEN_RELIABLE : HDR_LEN_FULL;

    always_comb
    begin
        state_next = state;
        take       = 1'b0;
        dec_byte   = 8'h00;
        emit       = 1'b0;

        // Header fields show the current registers; reliable mode zeroes seq_num and guaranteed
        result.header        = state.header;
        result.seq_num       = reliable_mode ? 8'h00 : state.seq;
        result.guaranteed    = reliable_mode ? 1'b0 : state.guaranteed;
        result.payload_byte  = state.held_byte;
        result.payload_valid = 1'b1;
        result.last          = 1'b0;

        if (in_byte == BYTE_DELIM)
        begin
            // Close the frame; report it only if the header is complete
            emit                 = (state.decoded_count >= hdr_len);
            result.last          = 1'b1;
            result.payload_valid = state.held_valid;
            result.payload_byte  = state.held_valid ? state.held_byte : 8'h00;
            state_next.group_left    = 8'h00;
            state_next.zero_pending  = 1'b0;
            state_next.decoded_count = 2'd0;
            state_next.held_valid    = 1'b0;
        end
        else if (state.group_left == 8'h00)
        begin
            // Code byte: release the previous group's zero, open a new group
            take                    = state.zero_pending;
            dec_byte                = 8'h00;
            state_next.zero_pending = (in_byte != CODE_FULL_GRP);
            state_next.group_left   = in_byte - 8'd1;
        end
        else
        begin
            // Literal byte inside a group
            take                  = 1'b1;
            dec_byte              = in_byte;
            state_next.group_left = state.group_left - 8'd1;
        end

        // Route the decoded byte to a header slot or the payload hold stage
        if (take)
        begin
            if (state.decoded_count < hdr_len)
            begin
                case (state.decoded_count)
                    HDR_SLOT_HEADER: state_next.header     = dec_byte;
                    HDR_SLOT_SEQ:    state_next.seq        = dec_byte;
                    default:         state_next.guaranteed = (dec_byte != 8'h00);
                endcase
                state_next.decoded_count = state.decoded_count + 2'd1;
            end
            else
            begin
                emit                  = state.held_valid;
                state_next.held_byte  = dec_byte;
                state_next.held_valid = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/cobs_stream_packet_deframer_core.sv
// COBS stream packet deframer: top level with handshakes, config port and registers.
// Depends on cobs_dfr_pkg and cobs_dfr_step.
//
// Usage:
//   Encoded bytes enter on the in_* valid/ready channel, one per request. A zero
//   byte ends a frame. Decoded frames leave on the out_* channel: each payload
//   byte is reported once the next one is decoded, and the delimiter produces
//   the final result of a frame with last set (payload_valid low if the frame
//   had no payload). Frames shorter than their header are dropped silently.
//   reliable_mode (APB, word 0) selects a one-byte header instead of three.
// Timing:
//   One request per cycle while no result is stalled. A result is visible in the
//   cycle after the byte that causes it is accepted; the decode state and the result
//   register are both updated at that edge by a single level of step logic.
// Stall:
//   in_ready is high while the result register is empty or being taken, so a
//   stalled receiver holds the result and back-pressures the input until it is taken.
// Reset:
//   rst_n clears the decode state, the header registers, reliable_mode and the
//   result register; in_ready is high out of reset, as the result register starts empty.
`default_nettype none

module cobs_stream_packet_deframer_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Encoded byte stream
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [7:0]                             in_byte,
    // Decoded results
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [7:0]                                  header,
    output logic [7:0]                                  seq_num,
    output logic                                        guaranteed,
    output logic [7:0]                                  payload_byte,
    output logic                                        payload_valid,
    output logic                                        last,
    // Configuration
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [cobs_dfr_pkg::ADDR_W-1:0]        paddr,
    input  wire logic [cobs_dfr_pkg::DATA_W-1:0]        pwdata,
    output logic [cobs_dfr_pkg::DATA_W-1:0]             prdata,
    output logic                                        pready
);
    import cobs_dfr_pkg::*;

    dfr_state_t  state_reg;
    dfr_state_t  state_next;
    dfr_result_t res_reg;
    dfr_result_t res_next;
    logic        emit;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        reliable_reg;
    logic        in_fire;
    logic        cfg_wr;
    logic        sel_reliable;

    // Decode one byte
    cobs_dfr_step u_step (
        .reliable_mode (reliable_reg),
        .in_byte       (in_byte),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (res_next),
        .emit          (emit)
    );

    // Handshakes
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (in_fire)
            out_valid_next = emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Configuration register access
    assign pready       = 1'b1;
    assign sel_reliable = (paddr[ADDR_W-1] == REG_RELIABLE_MODE);
    assign cfg_wr       = psel && penable && pwrite && sel_reliable;
    assign prdata       = sel_reliable ? {{(DATA_W-1){1'b0}}, reliable_reg} : '0;

    // Hold decode state, config and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            reliable_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr)
                reliable_reg <= pwdata[0];
        end
    end

    // Load the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_reg <= '0;
        else if (in_fire && emit)
            res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign header        = res_reg.header;
    assign seq_num       = res_reg.seq_num;
    assign guaranteed    = res_reg.guaranteed;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_valid = res_reg.payload_valid;
    assign last          = res_reg.last;

endmodule

`default_nettype wire

### sv/cobs_dfr_checker.sv
// Port-level checks for the COBS stream packet deframer, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module cobs_dfr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] header,
    input wire logic [7:0] seq_num,
    input wire logic       guaranteed,
    input wire logic [7:0] payload_byte,
    input wire logic       payload_valid,
    input wire logic       last
);

    // A stalled result holds its fields
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(header) && $stable(seq_num)
        && $stable(guaranteed) && $stable(payload_byte) && $stable(payload_valid)
        && $stable(last))
        else $error("result changed while stalled");

    // A full, stalled result register blocks new requests
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while result stalled");

    // A new result only follows an accepted byte
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without accepted byte");

    // An empty payload only marks the end of a frame
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> last)
        else $error("empty payload on non-final result");

    // An empty payload reports a zero byte
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'h00)
        else $error("empty payload with nonzero byte");

endmodule

bind cobs_stream_packet_deframer_core cobs_dfr_checker u_cobs_dfr_checker (.*);

`default_nettype wire
